### hdl/fcsd_pkg.sv
// ----------------------------------------------------------------------------
// fcsd_pkg
// Types, constants and the saturating add shared by the fixed-corotated
// sigma-derivative pipeline.
// ----------------------------------------------------------------------------
package fcsd_pkg;

    localparam int SPACE_DIM  = 3;
    localparam bit THREE_D    = (SPACE_DIM != 2);
    localparam int MUL_LANES  = 9;
    localparam int MUL_STAGES = 5;

    localparam logic [63:0] Q_ONE     = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q_NEG_ONE = 64'hFFFF_FFFF_0000_0000;
    localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;

    typedef logic [63:0] fcsd_q_t;
    typedef fcsd_q_t [2:0] fcsd_v3_t;
    typedef fcsd_q_t [MUL_LANES-1:0] fcsd_lanes_t;
    typedef logic [MUL_LANES-1:0] fcsd_flags_t;

    // lanes whose clamping only matters in 3D
    localparam fcsd_flags_t MUL_A_3D = 9'b100100000;
    localparam fcsd_flags_t MUL_B_3D = 9'b001101000;
    localparam fcsd_flags_t MUL_D_3D = 9'b100110000;
    localparam fcsd_flags_t MUL_F_3D = 9'b001101000;

    typedef struct packed {
        logic signed [31:0] sigma_a;
        logic signed [31:0] sigma_b;
        logic signed [31:0] sigma_c;
        logic [31:0]        shear_modulus;
        logic [31:0]        lame_first;
    } fcsd_in_t;

    typedef struct packed {
        logic signed [63:0] energy;
        logic signed [63:0] grad_a;
        logic signed [63:0] grad_b;
        logic signed [63:0] grad_c;
        logic signed [63:0] hess_aa;
        logic signed [63:0] hess_bb;
        logic signed [63:0] hess_cc;
        logic signed [63:0] hess_ab;
        logic signed [63:0] hess_ac;
        logic signed [63:0] hess_bc;
        logic               saturated;
    } fcsd_out_t;

    typedef struct packed {
        fcsd_v3_t s;
        fcsd_v3_t p;
        fcsd_v3_t e;
        fcsd_v3_t g;
        fcsd_v3_t lpi;
        fcsd_v3_t pp;
        fcsd_v3_t diag;
        fcsd_v3_t off;
        fcsd_q_t  mu;
        fcsd_q_t  lam;
        fcsd_q_t  two_mu;
        fcsd_q_t  half_lam;
        fcsd_q_t  sq;
        fcsd_q_t  jm1;
        fcsd_q_t  msq;
        fcsd_q_t  hj;
        fcsd_q_t  lp;
        logic     sat_all;
        logic     sat_3d;
    } fcsd_work_t;

    typedef struct packed {
        logic    sat;
        fcsd_q_t val;
    } fcsd_sum_t;

    function automatic fcsd_sum_t fcsd_qadd(input fcsd_q_t a, input fcsd_q_t b);
        fcsd_sum_t r;
        fcsd_q_t   s;
        s     = a + b;
        r.sat = 1'b0;
        r.val = s;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            r.sat = 1'b1;
            r.val = a[63] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

### hdl/fcsd_qmul.sv
// ----------------------------------------------------------------------------
// fcsd_qmul
// Five-stage Q32.32 multiplier: exact 128-bit product from 32x32 partial
// products, round half away from zero, saturate to signed 64 bits.
// ----------------------------------------------------------------------------
module fcsd_qmul import fcsd_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  fcsd_q_t a,
    input  fcsd_q_t b,
    output fcsd_q_t p,
    output logic    sat
);

    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [63:0] x_reg, y_reg;
    logic [63:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [33:0] mid_reg;
    logic [65:0] hisum_reg;
    logic        rnd_reg;
    logic        ovf_reg;
    logic [63:0] mag_reg;
    logic [97:0] rounded;
    fcsd_q_t     p_next, p_reg;
    logic        sat_next, sat_reg;

    assign rounded = {hisum_reg, 32'd0} + 98'(mid_reg) + 98'(rnd_reg);

    always_comb begin
        p_next   = mag_reg;
        sat_next = 1'b0;
        if (ovf_reg) begin
            p_next   = neg4_reg ? Q_MIN : Q_MAX;
            sat_next = 1'b1;
        end else if (!neg4_reg) begin
            if (mag_reg[63]) begin
                p_next   = Q_MAX;
                sat_next = 1'b1;
            end
        end else if (mag_reg[63] && (|mag_reg[62:0])) begin
            p_next   = Q_MIN;
            sat_next = 1'b1;
        end else begin
            p_next = 64'd0 - mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg  <= a[63] ^ b[63];
            x_reg     <= a[63] ? (64'd0 - a) : a;
            y_reg     <= b[63] ? (64'd0 - b) : b;
            neg2_reg  <= neg1_reg;
            pp00_reg  <= 64'(x_reg[31:0])  * 64'(y_reg[31:0]);
            pp01_reg  <= 64'(x_reg[31:0])  * 64'(y_reg[63:32]);
            pp10_reg  <= 64'(x_reg[63:32]) * 64'(y_reg[31:0]);
            pp11_reg  <= 64'(x_reg[63:32]) * 64'(y_reg[63:32]);
            neg3_reg  <= neg2_reg;
            mid_reg   <= 34'(pp00_reg[63:32]) + 34'(pp01_reg[31:0]) + 34'(pp10_reg[31:0]);
            hisum_reg <= 66'(pp11_reg) + 66'(pp01_reg[63:32]) + 66'(pp10_reg[63:32]);
            rnd_reg   <= pp00_reg[31];
            neg4_reg  <= neg3_reg;
            ovf_reg   <= |rounded[97:64];
            mag_reg   <= rounded[63:0];
            p_reg     <= p_next;
            sat_reg   <= sat_next;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

### hdl/fcsd_mul_step.sv
// ----------------------------------------------------------------------------
// fcsd_mul_step
// One multiply step of the pipeline: a row of Q32.32 multipliers and a
// matching delay line that carries the valid bit and the working set.
// ----------------------------------------------------------------------------
module fcsd_mul_step import fcsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        vld_in,
    input  fcsd_work_t  work_in,
    input  fcsd_lanes_t op_a,
    input  fcsd_lanes_t op_b,
    output logic        vld_out,
    output fcsd_work_t  work_out,
    output fcsd_lanes_t prod,
    output fcsd_flags_t sat
);

    logic [MUL_STAGES-1:0] vld_reg;
    fcsd_work_t            work_reg [MUL_STAGES];

    for (genvar i = 0; i < MUL_LANES; i++) begin : g_lane
        fcsd_qmul u_qmul (
            .aclk (aclk),
            .en   (en),
            .a    (op_a[i]),
            .b    (op_b[i]),
            .p    (prod[i]),
            .sat  (sat[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[MUL_STAGES-2:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg[0] <= work_in;
            for (int i = 1; i < MUL_STAGES; i++) begin
                work_reg[i] <= work_reg[i-1];
            end
        end
    end

    assign vld_out  = vld_reg[MUL_STAGES-1];
    assign work_out = work_reg[MUL_STAGES-1];

endmodule

### hdl/fixed_corotated_sigma_derivatives.sv
// ----------------------------------------------------------------------------
// fixed_corotated_sigma_derivatives
// Fixed-corotated energy, gradient and Hessian in singular-value space.
// ----------------------------------------------------------------------------
// Takes one element per clock while s_ready is high. The pipeline is four
// multiply steps of five stages each (magnitude, partial products, sum,
// round, saturate) plus four saturating-add stages and the input register.
// Multipliers are 32x32 partial products, four per Q32.32 product, 128 on
// the lanes in use. An output register backed by a one-entry skid buffer
// lets requests flow while a result waits; s_ready drops only when both
// are full.
module fixed_corotated_sigma_derivatives import fcsd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fcsd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output fcsd_out_t m_data
);

    logic        en;
    logic        in_valid_reg;
    fcsd_work_t  in_work_next, in_work_reg;

    fcsd_lanes_t a_op_a, a_op_b, a_prod;
    fcsd_flags_t a_sat;
    logic        a_vld;
    fcsd_work_t  a_work;
    fcsd_sum_t   a2_sq_sum;
    logic        a2_valid_reg;
    fcsd_work_t  a2_work_next, a2_work_reg;

    fcsd_lanes_t b_op_a, b_op_b, b_prod;
    fcsd_flags_t b_sat;
    logic        b_vld;
    fcsd_work_t  b_work;
    fcsd_sum_t   c_jm1_sum, c_sq_sum;
    logic        c_valid_reg;
    fcsd_work_t  c_work_next, c_work_reg;

    fcsd_lanes_t d_op_a, d_op_b, d_prod;
    fcsd_flags_t d_sat;
    logic        d_vld;
    fcsd_work_t  d_work;
    fcsd_sum_t   e_diag_sum [3];
    fcsd_sum_t   e_off_sum [3];
    logic        e_valid_reg;
    fcsd_work_t  e_work_next, e_work_reg;

    fcsd_lanes_t f_op_a, f_op_b, f_prod;
    fcsd_flags_t f_sat;
    logic        f_vld;
    fcsd_work_t  f_work;
    fcsd_sum_t   g_energy_sum;
    fcsd_sum_t   g_grad_sum [3];
    logic        g_sat_all, g_sat_3d;
    fcsd_out_t   last_data;

    logic        out_take;
    logic        out_valid_next, out_valid_reg;
    fcsd_out_t   out_data_next, out_data_reg;
    logic        skid_valid_next, skid_valid_reg;
    fcsd_out_t   skid_data_next, skid_data_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // widen operands to Q32.32
    always_comb begin
        in_work_next          = '0;
        in_work_next.s[0]     = {{28{s_data.sigma_a[31]}}, s_data.sigma_a, 4'b0000};
        in_work_next.s[1]     = {{28{s_data.sigma_b[31]}}, s_data.sigma_b, 4'b0000};
        in_work_next.s[2]     = THREE_D ? {{28{s_data.sigma_c[31]}}, s_data.sigma_c, 4'b0000}
                                        : Q_ONE;
        in_work_next.mu       = {8'd0, s_data.shear_modulus, 24'd0};
        in_work_next.lam      = {8'd0, s_data.lame_first, 24'd0};
        in_work_next.two_mu   = {7'd0, s_data.shear_modulus, 25'd0};
        in_work_next.half_lam = {9'd0, s_data.lame_first, 23'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_work_reg <= in_work_next;
        end
    end

    // step A: pair products, squared offsets, shear gradient terms
    always_comb begin
        a_op_a    = '0;
        a_op_b    = '0;
        a_op_a[0] = in_work_reg.s[1];
        a_op_b[0] = in_work_reg.s[2];
        a_op_a[1] = in_work_reg.s[2];
        a_op_b[1] = in_work_reg.s[0];
        a_op_a[2] = in_work_reg.s[0];
        a_op_b[2] = in_work_reg.s[1];
        a_op_a[3] = in_work_reg.s[0] - Q_ONE;
        a_op_b[3] = in_work_reg.s[0] - Q_ONE;
        a_op_a[4] = in_work_reg.s[1] - Q_ONE;
        a_op_b[4] = in_work_reg.s[1] - Q_ONE;
        a_op_a[5] = in_work_reg.s[2] - Q_ONE;
        a_op_b[5] = in_work_reg.s[2] - Q_ONE;
        a_op_a[6] = in_work_reg.two_mu;
        a_op_b[6] = in_work_reg.s[0] - Q_ONE;
        a_op_a[7] = in_work_reg.two_mu;
        a_op_b[7] = in_work_reg.s[1] - Q_ONE;
        a_op_a[8] = in_work_reg.two_mu;
        a_op_b[8] = in_work_reg.s[2] - Q_ONE;
    end

    fcsd_mul_step u_mul_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (in_valid_reg),
        .work_in  (in_work_reg),
        .op_a     (a_op_a),
        .op_b     (a_op_b),
        .vld_out  (a_vld),
        .work_out (a_work),
        .prod     (a_prod),
        .sat      (a_sat)
    );

    assign a2_sq_sum = fcsd_qadd(a_prod[3], a_prod[4]);

    always_comb begin
        a2_work_next         = a_work;
        a2_work_next.p[0]    = a_prod[0];
        a2_work_next.p[1]    = a_prod[1];
        a2_work_next.p[2]    = a_prod[2];
        a2_work_next.e[0]    = a_prod[3];
        a2_work_next.e[1]    = a_prod[4];
        a2_work_next.e[2]    = a_prod[5];
        a2_work_next.g[0]    = a_prod[6];
        a2_work_next.g[1]    = a_prod[7];
        a2_work_next.g[2]    = a_prod[8];
        a2_work_next.sq      = a2_sq_sum.val;
        a2_work_next.sat_all = a_work.sat_all | (|(a_sat & ~MUL_A_3D)) | a2_sq_sum.sat;
        a2_work_next.sat_3d  = a_work.sat_3d | (|(a_sat & MUL_A_3D));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a2_valid_reg <= 1'b0;
        end else if (en) begin
            a2_valid_reg <= a_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_work_reg <= a2_work_next;
        end
    end

    // step B: determinant, lambda-scaled cofactors, cofactor cross products
    always_comb begin
        b_op_a    = '0;
        b_op_b    = '0;
        b_op_a[0] = a2_work_reg.p[2];
        b_op_b[0] = a2_work_reg.s[2];
        b_op_a[1] = a2_work_reg.lam;
        b_op_b[1] = a2_work_reg.p[0];
        b_op_a[2] = a2_work_reg.lam;
        b_op_b[2] = a2_work_reg.p[1];
        b_op_a[3] = a2_work_reg.lam;
        b_op_b[3] = a2_work_reg.p[2];
        b_op_a[4] = a2_work_reg.p[0];
        b_op_b[4] = a2_work_reg.p[1];
        b_op_a[5] = a2_work_reg.p[0];
        b_op_b[5] = a2_work_reg.p[2];
        b_op_a[6] = a2_work_reg.p[2];
        b_op_b[6] = a2_work_reg.p[1];
    end

    fcsd_mul_step u_mul_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (a2_valid_reg),
        .work_in  (a2_work_reg),
        .op_a     (b_op_a),
        .op_b     (b_op_b),
        .vld_out  (b_vld),
        .work_out (b_work),
        .prod     (b_prod),
        .sat      (b_sat)
    );

    assign c_jm1_sum = fcsd_qadd(b_prod[0], Q_NEG_ONE);
    assign c_sq_sum  = fcsd_qadd(b_work.sq, b_work.e[2]);

    always_comb begin
        c_work_next         = b_work;
        c_work_next.jm1     = c_jm1_sum.val;
        c_work_next.sq      = c_sq_sum.val;
        c_work_next.lpi[0]  = b_prod[1];
        c_work_next.lpi[1]  = b_prod[2];
        c_work_next.lpi[2]  = b_prod[3];
        c_work_next.pp[0]   = b_prod[4];
        c_work_next.pp[1]   = b_prod[5];
        c_work_next.pp[2]   = b_prod[6];
        c_work_next.sat_all = b_work.sat_all | (|(b_sat & ~MUL_B_3D))
                            | c_jm1_sum.sat | c_sq_sum.sat;
        c_work_next.sat_3d  = b_work.sat_3d | (|(b_sat & MUL_B_3D));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_work_reg <= c_work_next;
        end
    end

    // step D: terms scaled by J - 1, diagonal curvature
    always_comb begin
        d_op_a    = '0;
        d_op_b    = '0;
        d_op_a[0] = c_work_reg.mu;
        d_op_b[0] = c_work_reg.sq;
        d_op_a[1] = c_work_reg.half_lam;
        d_op_b[1] = c_work_reg.jm1;
        d_op_a[2] = c_work_reg.lam;
        d_op_b[2] = c_work_reg.jm1;
        d_op_a[3] = c_work_reg.s[2];
        d_op_b[3] = c_work_reg.jm1;
        d_op_a[4] = c_work_reg.s[1];
        d_op_b[4] = c_work_reg.jm1;
        d_op_a[5] = c_work_reg.s[0];
        d_op_b[5] = c_work_reg.jm1;
        d_op_a[6] = c_work_reg.lpi[0];
        d_op_b[6] = c_work_reg.p[0];
        d_op_a[7] = c_work_reg.lpi[1];
        d_op_b[7] = c_work_reg.p[1];
        d_op_a[8] = c_work_reg.lpi[2];
        d_op_b[8] = c_work_reg.p[2];
    end

    fcsd_mul_step u_mul_d (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (c_valid_reg),
        .work_in  (c_work_reg),
        .op_a     (d_op_a),
        .op_b     (d_op_b),
        .vld_out  (d_vld),
        .work_out (d_work),
        .prod     (d_prod),
        .sat      (d_sat)
    );

    for (genvar i = 0; i < 3; i++) begin : g_step_e
        assign e_diag_sum[i] = fcsd_qadd(d_work.two_mu, d_prod[6+i]);
        assign e_off_sum[i]  = fcsd_qadd(d_prod[3+i], d_work.pp[i]);
    end

    always_comb begin
        e_work_next         = d_work;
        e_work_next.msq     = d_prod[0];
        e_work_next.hj      = d_prod[1];
        e_work_next.lp      = d_prod[2];
        e_work_next.diag[0] = e_diag_sum[0].val;
        e_work_next.diag[1] = e_diag_sum[1].val;
        e_work_next.diag[2] = e_diag_sum[2].val;
        e_work_next.off[0]  = e_off_sum[0].val;
        e_work_next.off[1]  = e_off_sum[1].val;
        e_work_next.off[2]  = e_off_sum[2].val;
        e_work_next.sat_all = d_work.sat_all | (|(d_sat & ~MUL_D_3D))
                            | e_diag_sum[0].sat | e_diag_sum[1].sat | e_off_sum[0].sat;
        e_work_next.sat_3d  = d_work.sat_3d | (|(d_sat & MUL_D_3D))
                            | e_diag_sum[2].sat | e_off_sum[1].sat | e_off_sum[2].sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_work_reg <= e_work_next;
        end
    end

    // step F: volume energy, volume gradient, off-diagonal scaling
    always_comb begin
        f_op_a    = '0;
        f_op_b    = '0;
        f_op_a[0] = e_work_reg.hj;
        f_op_b[0] = e_work_reg.jm1;
        f_op_a[1] = e_work_reg.p[0];
        f_op_b[1] = e_work_reg.lp;
        f_op_a[2] = e_work_reg.p[1];
        f_op_b[2] = e_work_reg.lp;
        f_op_a[3] = e_work_reg.p[2];
        f_op_b[3] = e_work_reg.lp;
        f_op_a[4] = e_work_reg.lam;
        f_op_b[4] = e_work_reg.off[0];
        f_op_a[5] = e_work_reg.lam;
        f_op_b[5] = e_work_reg.off[1];
        f_op_a[6] = e_work_reg.lam;
        f_op_b[6] = e_work_reg.off[2];
    end

    fcsd_mul_step u_mul_f (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (e_valid_reg),
        .work_in  (e_work_reg),
        .op_a     (f_op_a),
        .op_b     (f_op_b),
        .vld_out  (f_vld),
        .work_out (f_work),
        .prod     (f_prod),
        .sat      (f_sat)
    );

    assign g_energy_sum = fcsd_qadd(f_work.msq, f_prod[0]);

    for (genvar i = 0; i < 3; i++) begin : g_step_g
        assign g_grad_sum[i] = fcsd_qadd(f_work.g[i], f_prod[1+i]);
    end

    assign g_sat_all = f_work.sat_all | (|(f_sat & ~MUL_F_3D))
                     | g_energy_sum.sat | g_grad_sum[0].sat | g_grad_sum[1].sat;
    assign g_sat_3d  = f_work.sat_3d | (|(f_sat & MUL_F_3D)) | g_grad_sum[2].sat;

    // drop third-axis terms in 2D
    always_comb begin
        last_data.energy    = g_energy_sum.val;
        last_data.grad_a    = g_grad_sum[0].val;
        last_data.grad_b    = g_grad_sum[1].val;
        last_data.grad_c    = THREE_D ? g_grad_sum[2].val : '0;
        last_data.hess_aa   = f_work.diag[0];
        last_data.hess_bb   = f_work.diag[1];
        last_data.hess_cc   = THREE_D ? f_work.diag[2] : '0;
        last_data.hess_ab   = f_prod[4];
        last_data.hess_ac   = THREE_D ? f_prod[5] : '0;
        last_data.hess_bc   = THREE_D ? f_prod[6] : '0;
        last_data.saturated = g_sat_all | (THREE_D & g_sat_3d);
    end

    // output register with skid buffer
    assign out_take = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else begin
            if (out_take) begin
                out_valid_next = 1'b0;
            end
            if (f_vld) begin
                if (!out_valid_reg || out_take) begin
                    out_valid_next = 1'b1;
                    out_data_next  = last_data;
                end else begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = last_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("skid result dropped without a handshake");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled while the output could move");

endmodule
